[design/rabf_pkg.sv]
// Shared types, constants and codes of the RGBA rectangle blend-fill unit.
package rabf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int EDGE_W       = 12;
    localparam int CHAN_W       = 8;
    localparam int PIXEL_W      = 32;
    localparam int SURF_W       = 9;
    localparam int READ_COORD_W = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 9;

    // Coordinates in the command queue must hold the largest store width itself.
    localparam int COORD_W = 13;
    // Signed width used for clipping the 12-bit edges against the surface.
    localparam int CLIP_W  = 14;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [SURF_W-1:0] SURF_RESET   = 9'd256;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

    typedef enum logic
    {
        REQ_FILL = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_SURFACE_WIDTH  = 1'b0,
        REG_SURFACE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Stored pixel layout: red in the low byte, alpha in the high byte.
    typedef struct packed
    {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed
    {
        req_kind_t          kind;
        logic               skip;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        pixel_t             color;
    } cmd_t;

endpackage

[design/rabf_channels.sv]
// Request and reply channel interfaces of the RGBA rectangle blend-fill unit.
interface rabf_req_if;
    import rabf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic signed [EDGE_W-1:0]       rect_left;
    logic signed [EDGE_W-1:0]       rect_top;
    logic signed [EDGE_W-1:0]       rect_right;
    logic signed [EDGE_W-1:0]       rect_bottom;
    logic        [CHAN_W-1:0]       fill_red;
    logic        [CHAN_W-1:0]       fill_green;
    logic        [CHAN_W-1:0]       fill_blue;
    logic        [CHAN_W-1:0]       fill_alpha;
    logic        [READ_COORD_W-1:0] read_x;
    logic        [READ_COORD_W-1:0] read_y;

    modport source
    (
        output valid, req_type, rect_left, rect_top, rect_right, rect_bottom,
               fill_red, fill_green, fill_blue, fill_alpha, read_x, read_y,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, rect_left, rect_top, rect_right, rect_bottom,
               fill_red, fill_green, fill_blue, fill_alpha, read_x, read_y,
        output ready
    );
endinterface

interface rabf_rsp_if;
    import rabf_pkg::*;

    logic              valid;
    logic              ready;
    logic              reply_kind;
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic [CHAN_W-1:0] pixel_alpha;

    modport source
    (
        output valid, reply_kind, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        input  ready
    );

    modport sink
    (
        input  valid, reply_kind, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        output ready
    );
endinterface

[design/rgba_rect_alpha_blend_fill_unit.sv]
// Top level of the RGBA rectangle blend-fill unit with pixel read-back.
//
//   Channel  Direction  Handshake              Carries
//   -------  ---------  ---------------------  -------------------------------------------
//   req      in         valid/ready            fill rectangle and colour, or read x/y
//   rsp      out        valid/ready            reply kind and read pixel (zero for fills)
//   cfg      in         cfg_we, no back-press  surface_width (index 0), surface_height (1)
//
// A read, or a fill that changes nothing, passes from the queue through the back end's
// command register to the reply register; a fill that touches pixels first walks every
// clipped pixel, as the store's single read and write ports walk one pixel per cycle.
// After reset all MAX_HEIGHT * 2**clog2(MAX_WIDTH) words of the store (65536 at the default
// size) are swept to zero while req.ready stays low. Up to four requests wait in the
// queue, and a finished reply waits in its own register while the next request starts.
module rgba_rect_alpha_blend_fill_unit #(
    parameter int MAX_WIDTH  = rabf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rabf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rabf_req_if.sink                         req,
    rabf_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [rabf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rabf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rabf_pkg::*;

    // Front end to queue.
    logic q_push;
    cmd_t q_push_data;
    logic q_full;

    // Queue to back end.
    logic q_pop;
    cmd_t q_pop_data;
    logic q_empty;

    // Low while the frame store is being cleared after reset.
    logic store_ready;

    // The front end clips each fill rectangle against the surface and flags requests
    // that need no store access, so the back end only walks real pixels.
    rabf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .store_ready (store_ready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    rabf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // The back end owns the frame store. Each command runs to completion and the
    // blend pipeline drains before the next one starts, so a later command always
    // sees the pixels written by an earlier one.
    rabf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .store_ready (store_ready),
        .rsp         (rsp)
    );

endmodule

[design/rabf_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module rabf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/rabf_queue.sv]
// Short command queue between the front end and the back end.
module rabf_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rabf_pkg::cmd_t   push_data,
    output logic             full,
    input  logic             pop,
    output rabf_pkg::cmd_t   pop_data,
    output logic             empty
);
    import rabf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/rabf_front.sv]
// Front end: surface registers, request acceptance, rectangle clipping and classification.
module rabf_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rabf_req_if.sink                           req,
    input  logic                               cfg_we,
    input  logic [rabf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rabf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               store_ready,
    input  logic                               q_full,
    output logic                               q_push,
    output rabf_pkg::cmd_t                     q_data
);
    import rabf_pkg::*;

    localparam logic signed [CLIP_W-1:0] MAX_W_S = CLIP_W'(MAX_WIDTH);
    localparam logic signed [CLIP_W-1:0] MAX_H_S = CLIP_W'(MAX_HEIGHT);
    localparam logic        [CLIP_W-1:0] MAX_W_U = CLIP_W'(MAX_WIDTH);
    localparam logic        [CLIP_W-1:0] MAX_H_U = CLIP_W'(MAX_HEIGHT);

    logic [SURF_W-1:0] surface_width_reg;
    logic [SURF_W-1:0] surface_width_next;
    logic [SURF_W-1:0] surface_height_reg;
    logic [SURF_W-1:0] surface_height_next;

    logic signed [CLIP_W-1:0] sw_s;
    logic signed [CLIP_W-1:0] sh_s;
    logic signed [CLIP_W-1:0] w_lim;
    logic signed [CLIP_W-1:0] h_lim;
    logic signed [CLIP_W-1:0] left_s;
    logic signed [CLIP_W-1:0] top_s;
    logic signed [CLIP_W-1:0] right_s;
    logic signed [CLIP_W-1:0] bottom_s;
    logic signed [CLIP_W-1:0] left_c;
    logic signed [CLIP_W-1:0] top_c;
    logic signed [CLIP_W-1:0] right_c;
    logic signed [CLIP_W-1:0] bottom_c;
    logic        [CLIP_W-1:0] rx_ext;
    logic        [CLIP_W-1:0] ry_ext;
    logic                     fill_empty;
    logic                     read_outside;

    // Surface registers; a write to an index beyond the list is ignored.
    always_comb
    begin
        surface_width_next  = surface_width_reg;
        surface_height_next = surface_height_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SURFACE_WIDTH:  surface_width_next  = cfg_data;
                REG_SURFACE_HEIGHT: surface_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= SURF_RESET;
            surface_height_reg <= SURF_RESET;
        end
        else
        begin
            surface_width_reg  <= surface_width_next;
            surface_height_reg <= surface_height_next;
        end
    end

    // Clip limits: a surface larger than the store acts as the store size.
    assign sw_s  = $signed(CLIP_W'(surface_width_reg));
    assign sh_s  = $signed(CLIP_W'(surface_height_reg));
    assign w_lim = (sw_s > MAX_W_S) ? MAX_W_S : sw_s;
    assign h_lim = (sh_s > MAX_H_S) ? MAX_H_S : sh_s;

    assign left_s   = CLIP_W'(req.rect_left);
    assign top_s    = CLIP_W'(req.rect_top);
    assign right_s  = CLIP_W'(req.rect_right);
    assign bottom_s = CLIP_W'(req.rect_bottom);

    assign left_c   = left_s[CLIP_W-1] ? '0 : left_s;
    assign top_c    = top_s[CLIP_W-1] ? '0 : top_s;
    assign right_c  = (right_s > w_lim) ? w_lim : right_s;
    assign bottom_c = (bottom_s > h_lim) ? h_lim : bottom_s;

    // A fill with no pixels inside, or with a transparent colour, changes nothing.
    assign fill_empty = (right_c <= left_c) || (bottom_c <= top_c)
                        || (req.fill_alpha == ALPHA_CLEAR);

    assign rx_ext       = CLIP_W'(req.read_x);
    assign ry_ext       = CLIP_W'(req.read_y);
    assign read_outside = (rx_ext >= MAX_W_U) || (ry_ext >= MAX_H_U);

    always_comb
    begin
        q_data.kind        = req_kind_t'(req.req_type);
        q_data.color.red   = req.fill_red;
        q_data.color.green = req.fill_green;
        q_data.color.blue  = req.fill_blue;
        q_data.color.alpha = req.fill_alpha;
        if (req_kind_t'(req.req_type) == REQ_FILL)
        begin
            q_data.skip = fill_empty;
            q_data.x0   = left_c[COORD_W-1:0];
            q_data.x1   = right_c[COORD_W-1:0];
            q_data.y0   = top_c[COORD_W-1:0];
            q_data.y1   = bottom_c[COORD_W-1:0];
        end
        else
        begin
            q_data.skip = read_outside;
            q_data.x0   = rx_ext[COORD_W-1:0];
            q_data.x1   = '0;
            q_data.y0   = ry_ext[COORD_W-1:0];
            q_data.y1   = '0;
        end
    end

    assign req.ready = store_ready && !q_full;
    assign q_push    = req.valid && req.ready;

endmodule

[design/rabf_back.sv]
// Back end: frame store clearing, pixel walk, blend pipeline and reply register.
module rabf_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  rabf_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           store_ready,
    rabf_rsp_if.source     rsp
);
    import rabf_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** XW);
    localparam int MIX_W = 16;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_REPLY
    } state_t;

    state_t           state_reg;
    logic [AW-1:0]    clr_addr_reg;
    cmd_t             cmd_reg;
    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic             rsp_valid_reg;
    req_kind_t        rsp_kind_reg;
    pixel_t           rsp_pixel_reg;

    logic             p1_valid_reg;
    logic [AW-1:0]    p1_addr_reg;
    logic             p2_valid_reg;
    logic [AW-1:0]    p2_addr_reg;
    logic             p2_over_reg;
    logic [MIX_W-1:0] p2_sum_r_reg;
    logic [MIX_W-1:0] p2_sum_g_reg;
    logic [MIX_W-1:0] p2_sum_b_reg;
    logic [CHAN_W-1:0] p2_alpha_reg;

    logic             walk_read;
    logic             idle_read;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;
    logic [PIXEL_W-1:0] ram_rdata;
    logic             x_last;
    logic             y_last;
    logic             out_free;
    pixel_t           dst;
    pixel_t           blended;
    logic             s1_over;
    logic [CHAN_W-1:0] s1_alpha;

    // Weighted sum of source and destination; at most 255*255.
    function automatic logic [MIX_W-1:0] mix(input logic [CHAN_W-1:0] s,
                                             input logic [CHAN_W-1:0] d,
                                             input logic [CHAN_W-1:0] a);
        return MIX_W'(s) * MIX_W'(a) + MIX_W'(d) * MIX_W'(ALPHA_OPAQUE - a);
    endfunction

    // Exact truncating division by 255 for sums up to 255*255.
    function automatic logic [CHAN_W-1:0] div255(input logic [MIX_W-1:0] n);
        logic [MIX_W:0] t;
        t = (MIX_W+1)'(n) + (MIX_W+1)'(n[MIX_W-1:CHAN_W]) + (MIX_W+1)'(1);
        return t[MIX_W-1:CHAN_W];
    endfunction

    assign store_ready = (state_reg != ST_CLEAR);
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_free    = !rsp_valid_reg || rsp.ready;

    assign walk_read = (state_reg == ST_WALK);
    assign idle_read = q_pop && (q_data.kind == REQ_READ) && !q_data.skip;
    assign ram_re    = walk_read || idle_read;
    assign ram_raddr = walk_read ? {y_reg, x_reg} : {q_data.y0[YW-1:0], q_data.x0[XW-1:0]};

    assign x_last = ((COORD_W'(x_reg) + COORD_W'(1)) == cmd_reg.x1);
    assign y_last = ((COORD_W'(y_reg) + COORD_W'(1)) == cmd_reg.y1);

    // Stage 1: destination pixel arrives from the store; form the products.
    assign dst      = pixel_t'(ram_rdata);
    assign s1_over  = (cmd_reg.color.alpha == ALPHA_OPAQUE) || (dst.alpha == ALPHA_CLEAR);
    assign s1_alpha = (dst.alpha > cmd_reg.color.alpha) ? dst.alpha : cmd_reg.color.alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= walk_read;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_addr_reg  <= ram_raddr;
        p2_addr_reg  <= p1_addr_reg;
        p2_over_reg  <= s1_over;
        p2_alpha_reg <= s1_alpha;
        p2_sum_r_reg <= mix(cmd_reg.color.red, dst.red, cmd_reg.color.alpha);
        p2_sum_g_reg <= mix(cmd_reg.color.green, dst.green, cmd_reg.color.alpha);
        p2_sum_b_reg <= mix(cmd_reg.color.blue, dst.blue, cmd_reg.color.alpha);
    end

    // Stage 2: divide and write back, or overwrite with the fill colour.
    always_comb
    begin
        if (p2_over_reg)
        begin
            blended = cmd_reg.color;
        end
        else
        begin
            blended.red   = div255(p2_sum_r_reg);
            blended.green = div255(p2_sum_g_reg);
            blended.blue  = div255(p2_sum_b_reg);
            blended.alpha = p2_alpha_reg;
        end
    end

    assign ram_we    = (state_reg == ST_CLEAR) || p2_valid_reg;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : p2_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : PIXEL_W'(blended);

    rabf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cmd_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_kind_reg  <= REQ_FILL;
            rsp_pixel_reg <= '0;
        end
        else
        begin
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_data;
                        x_reg   <= q_data.x0[XW-1:0];
                        y_reg   <= q_data.y0[YW-1:0];
                        if ((q_data.kind == REQ_FILL) && !q_data.skip)
                        begin
                            state_reg <= ST_WALK;
                        end
                        else
                        begin
                            state_reg <= ST_REPLY;
                        end
                    end
                end
                ST_WALK:
                begin
                    if (x_last)
                    begin
                        x_reg <= cmd_reg.x0[XW-1:0];
                        if (y_last)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            y_reg <= y_reg + YW'(1);
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + XW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!p1_valid_reg && !p2_valid_reg)
                    begin
                        state_reg <= ST_REPLY;
                    end
                end
                ST_REPLY:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_kind_reg  <= cmd_reg.kind;
                        if ((cmd_reg.kind == REQ_READ) && !cmd_reg.skip)
                        begin
                            rsp_pixel_reg <= pixel_t'(ram_rdata);
                        end
                        else
                        begin
                            rsp_pixel_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.reply_kind  = rsp_kind_reg;
    assign rsp.pixel_red   = rsp_pixel_reg.red;
    assign rsp.pixel_green = rsp_pixel_reg.green;
    assign rsp.pixel_blue  = rsp_pixel_reg.blue;
    assign rsp.pixel_alpha = rsp_pixel_reg.alpha;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench of the RGBA rectangle blend-fill unit: directed script, random fills and reads.
module tb;
    import rabf_pkg::*;

    // The store geometry follows the block's default parameters.
    localparam int FRAME_W = DEF_MAX_WIDTH;
    localparam int FRAME_H = DEF_MAX_HEIGHT;

    // A full-surface fill walks 65536 pixels, and so does the clearing sweep after reset.
    // Nothing may be accepted on either channel for that long, so the limit on quiet
    // cycles sits a few times above it.
    localparam int STALL_LIMIT = 300000;

    // Random requests per idling phase, and how many of them share one paint window.
    localparam int RANDOM_PER_PHASE = 510;
    localparam int SCENE_LEN        = 64;
    localparam int WINDOW_SPAN      = 24;

    // Cycles allowed after the last reply before the verdict.
    localparam int TAIL_CYCLES = 20;

    localparam int MAX_SHOWN = 10;

    typedef struct {
        req_kind_t                kind;
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        pixel_t                   color;
        logic [READ_COORD_W-1:0]  x;
        logic [READ_COORD_W-1:0]  y;
    } blend_req_t;

    typedef struct packed {
        req_kind_t kind;
        pixel_t    pix;
    } reply_t;

    typedef enum {
        ROW_REQUEST,
        ROW_REGISTER
    } row_kind_t;

    // One line of the directed script: either a request or a register write. A request
    // row may carry a reply typed in by hand, which then replaces the predicted one.
    typedef struct {
        row_kind_t              kind;
        cfg_reg_t               reg_sel;
        logic [CFG_DATA_W-1:0]  reg_val;
        blend_req_t             item;
        bit                     typed;
        reply_t                 reply;
    } script_row_t;

    localparam reply_t FILL_DONE = '{kind: REQ_FILL, pix: '0};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rabf_req_if req();
    rabf_rsp_if rsp();

    rgba_rect_alpha_blend_fill_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the frame store and of the two surface registers. The predictor
    // works on these in the order in which the block accepts requests.
    pixel_t              shadow_frame [FRAME_W*FRAME_H];
    logic [SURF_W-1:0]   shadow_w = SURF_RESET;
    logic [SURF_W-1:0]   shadow_h = SURF_RESET;

    // Replies still owed by the block, oldest first.
    reply_t pending_replies [$];

    script_row_t plan [$];

    int send_idle_pct;
    int recv_idle_pct;

    int fill_count;
    int read_count;
    int mixed_pixels;
    int overwritten_pixels;
    int reply_count;
    int reg_writes;
    int fault_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Blend of one colour channel, truncated as the block does it.
    function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] s,
                                                   logic [CHAN_W-1:0] d,
                                                   logic [CHAN_W-1:0] a);
        int full;
        int sum;
        full = int'(ALPHA_OPAQUE);
        sum  = (int'(s) * int'(a) + int'(d) * (full - int'(a))) / full;
        return CHAN_W'(sum);
    endfunction

    // Applies one request to the shadow store and returns the reply it must produce.
    function automatic reply_t predict_reply(blend_req_t r);
        reply_t rep;
        pixel_t d;
        int     w;
        int     h;
        int     l;
        int     t;
        int     rt;
        int     b;
        int     idx;
        rep      = FILL_DONE;
        rep.kind = r.kind;
        if (r.kind == REQ_READ)
        begin
            read_count++;
            // Reads ignore the surface size; only coordinates past the store read zero.
            if (int'(r.x) < FRAME_W && int'(r.y) < FRAME_H)
                rep.pix = shadow_frame[int'(r.y) * FRAME_W + int'(r.x)];
            return rep;
        end
        fill_count++;
        // Oversized registers act as the store size, a zero register empties every fill.
        w  = (int'(shadow_w) > FRAME_W) ? FRAME_W : int'(shadow_w);
        h  = (int'(shadow_h) > FRAME_H) ? FRAME_H : int'(shadow_h);
        l  = int'(r.left);
        t  = int'(r.top);
        rt = int'(r.right);
        b  = int'(r.bottom);
        if (l < 0)
            l = 0;
        if (t < 0)
            t = 0;
        if (rt > w)
            rt = w;
        if (b > h)
            b = h;
        if (r.color.alpha == ALPHA_CLEAR)
            return rep;
        for (int yy = t; yy < b; yy++)
        begin
            for (int xx = l; xx < rt; xx++)
            begin
                idx = yy * FRAME_W + xx;
                d   = shadow_frame[idx];
                if (r.color.alpha == ALPHA_OPAQUE || d.alpha == ALPHA_CLEAR)
                begin
                    shadow_frame[idx] = r.color;
                    overwritten_pixels++;
                end
                else
                begin
                    shadow_frame[idx].red   = mix_chan(r.color.red, d.red, r.color.alpha);
                    shadow_frame[idx].green = mix_chan(r.color.green, d.green, r.color.alpha);
                    shadow_frame[idx].blue  = mix_chan(r.color.blue, d.blue, r.color.alpha);
                    shadow_frame[idx].alpha = (d.alpha > r.color.alpha) ? d.alpha
                                                                        : r.color.alpha;
                    mixed_pixels++;
                end
            end
        end
        return rep;
    endfunction

    function automatic pixel_t rgba(int r, int g, int b, int a);
        pixel_t p;
        p.red   = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue  = CHAN_W'(b);
        p.alpha = CHAN_W'(a);
        return p;
    endfunction

    function automatic reply_t pixel_reply(pixel_t p);
        reply_t rep;
        rep.kind = REQ_READ;
        rep.pix  = p;
        return rep;
    endfunction

    function automatic script_row_t blank_row();
        script_row_t row;
        row.kind        = ROW_REQUEST;
        row.reg_sel     = REG_SURFACE_WIDTH;
        row.reg_val     = '0;
        row.item.kind   = REQ_FILL;
        row.item.left   = '0;
        row.item.top    = '0;
        row.item.right  = '0;
        row.item.bottom = '0;
        row.item.color  = '0;
        row.item.x      = '0;
        row.item.y      = '0;
        row.typed       = 1'b0;
        row.reply       = FILL_DONE;
        return row;
    endfunction

    function automatic script_row_t fill_row(int l, int t, int r, int b, pixel_t c);
        script_row_t row;
        row             = blank_row();
        row.item.left   = EDGE_W'(l);
        row.item.top    = EDGE_W'(t);
        row.item.right  = EDGE_W'(r);
        row.item.bottom = EDGE_W'(b);
        row.item.color  = c;
        return row;
    endfunction

    function automatic script_row_t read_row(int x, int y);
        script_row_t row;
        row           = blank_row();
        row.item.kind = REQ_READ;
        row.item.x    = READ_COORD_W'(x);
        row.item.y    = READ_COORD_W'(y);
        return row;
    endfunction

    function automatic script_row_t reg_row(cfg_reg_t sel, int value);
        script_row_t row;
        row         = blank_row();
        row.kind    = ROW_REGISTER;
        row.reg_sel = sel;
        row.reg_val = CFG_DATA_W'(value);
        return row;
    endfunction

    function automatic script_row_t checked(script_row_t row, reply_t rep);
        row.typed = 1'b1;
        row.reply = rep;
        return row;
    endfunction

    // Appends one line to the directed script.
    function automatic void add_row(script_row_t row);
        plan.insert(plan.size(), row);
    endfunction

    // Random request around a paint window, so that fills pile up on each other and
    // reads mostly land on painted pixels. A share of fills takes full-range edges on
    // one axis while the other axis stays narrow, which keeps the pixel count bounded.
    function automatic blend_req_t random_request(int wx, int wy);
        blend_req_t r;
        int         pick;
        int         lo;
        int         roll;
        r.kind   = REQ_FILL;
        r.color  = pixel_t'($urandom);
        r.x      = READ_COORD_W'($urandom);
        r.y      = READ_COORD_W'($urandom);
        r.left   = EDGE_W'($urandom);
        r.top    = EDGE_W'($urandom);
        r.right  = EDGE_W'($urandom);
        r.bottom = EDGE_W'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 35)
        begin
            r.kind = REQ_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                r.x = READ_COORD_W'(wx + $urandom_range(0, WINDOW_SPAN - 1));
                r.y = READ_COORD_W'(wy + $urandom_range(0, WINDOW_SPAN - 1));
            end
            return r;
        end
        roll = $urandom_range(0, 99);
        if (roll < 15)
            r.color.alpha = ALPHA_OPAQUE;
        else if (roll < 25)
            r.color.alpha = ALPHA_CLEAR;
        else if (roll < 30)
            r.color.alpha = 8'd1;
        else if (roll < 35)
            r.color.alpha = 8'd254;
        // Edges may land a little before the window and may come out empty or reversed.
        if (pick < 90)
        begin
            lo      = wx + $urandom_range(0, WINDOW_SPAN + 3) - 4;
            r.left  = EDGE_W'(lo);
            r.right = EDGE_W'(lo + $urandom_range(0, 14) - 2);
        end
        if (pick < 85 || pick >= 90)
        begin
            lo       = wy + $urandom_range(0, WINDOW_SPAN + 3) - 4;
            r.top    = EDGE_W'(lo);
            r.bottom = EDGE_W'(lo + $urandom_range(0, 14) - 2);
        end
        return r;
    endfunction

    // Offers one request, with random idle cycles first, and predicts its reply at the
    // edge where the block takes it. Valid stays high until the request is accepted.
    task automatic issue(input blend_req_t r, input bit typed, input reply_t typed_rep);
        reply_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= r.kind;
        req.rect_left   <= r.left;
        req.rect_top    <= r.top;
        req.rect_right  <= r.right;
        req.rect_bottom <= r.bottom;
        req.fill_red    <= r.color.red;
        req.fill_green  <= r.color.green;
        req.fill_blue   <= r.color.blue;
        req.fill_alpha  <= r.color.alpha;
        req.read_x      <= r.x;
        req.read_y      <= r.y;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = predict_reply(r);
        if (typed)
            predicted = typed_rep;
        pending_replies.insert(pending_replies.size(), predicted);
    endtask

    // Register writes only happen once every reply is back, so the block is idle.
    // Every request produces a reply, so no extra settling time is needed.
    task automatic write_surface(input cfg_reg_t sel, input int value);
        req.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (sel == REG_SURFACE_WIDTH)
            shadow_w = SURF_W'(value);
        else
            shadow_h = SURF_W'(value);
        reg_writes++;
        @(posedge clk);
    endtask

    // Reply side: checks every accepted reply against the oldest expectation, then
    // decides ready for the next cycle. Values seen here are those before the edge.
    initial
    begin
        reply_t got;
        reply_t want;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.kind      = req_kind_t'(rsp.reply_kind);
                got.pix.red   = rsp.pixel_red;
                got.pix.green = rsp.pixel_green;
                got.pix.blue  = rsp.pixel_blue;
                got.pix.alpha = rsp.pixel_alpha;
                if (pending_replies.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                        $display("ERROR: unexpected reply: kind %0d rgba %h",
                                 got.kind, got.pix);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    reply_count++;
                    if (got.kind !== want.kind || got.pix.red !== want.pix.red ||
                        got.pix.green !== want.pix.green || got.pix.blue !== want.pix.blue ||
                        got.pix.alpha !== want.pix.alpha)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_SHOWN)
                        begin
                            $write("ERROR: reply %0d: expected kind %0d r %0d g %0d b %0d a %0d",
                                   reply_count, want.kind, want.pix.red, want.pix.green,
                                   want.pix.blue, want.pix.alpha);
                            $display(", got kind %0d r %0d g %0d b %0d a %0d",
                                     got.kind, got.pix.red, got.pix.green, got.pix.blue,
                                     got.pix.alpha);
                        end
                    end
                end
            end
            rsp.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ERROR: nothing accepted for %0d cycles, %0d replies outstanding",
                         STALL_LIMIT, pending_replies.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int wx;
        int wy;
        int span_x;
        int span_y;

        foreach (shadow_frame[i])
            shadow_frame[i] = '0;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        req.valid       <= 1'b0;
        req.req_type    <= REQ_FILL;
        req.rect_left   <= '0;
        req.rect_top    <= '0;
        req.rect_right  <= '0;
        req.rect_bottom <= '0;
        req.fill_red    <= '0;
        req.fill_green  <= '0;
        req.fill_blue   <= '0;
        req.fill_alpha  <= '0;
        req.read_x      <= '0;
        req.read_y      <= '0;

        send_idle_pct = 31;
        recv_idle_pct = 78;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed script. The store starts cleared, so the first reads must be zero.
        add_row(checked(read_row(0, 0), pixel_reply('0)));
        add_row(checked(read_row(255, 255), pixel_reply('0)));
        // Full-range edges with a clear source alpha: the fill is skipped without a walk and
        // nothing changes.
        add_row(checked(fill_row(-2048, -2048, 2047, 2047, rgba(90, 165, 255, 0)),
                        FILL_DONE));
        add_row(checked(read_row(128, 77), pixel_reply('0)));
        // A clear destination takes the colour as it is, alpha included.
        add_row(checked(fill_row(0, 0, 4, 4, rgba(200, 100, 50, 100)), FILL_DONE));
        add_row(checked(read_row(1, 1), pixel_reply(rgba(200, 100, 50, 100))));
        // Overlap with a half-transparent colour goes through the blend path.
        add_row(fill_row(2, 2, 6, 6, rgba(10, 250, 0, 128)));
        add_row(read_row(2, 2));
        add_row(read_row(5, 5));
        // An opaque source overwrites whatever is there.
        add_row(checked(fill_row(1, 1, 3, 3, rgba(1, 2, 3, 255)), FILL_DONE));
        add_row(checked(read_row(2, 2), pixel_reply(rgba(1, 2, 3, 255))));
        // Zero width: every fill does nothing.
        add_row(reg_row(REG_SURFACE_WIDTH, 0));
        add_row(checked(fill_row(0, 0, 10, 10, rgba(9, 9, 9, 255)), FILL_DONE));
        add_row(checked(read_row(0, 0), pixel_reply(rgba(200, 100, 50, 100))));
        // Oversized width acts as the store width; a one-row surface.
        add_row(reg_row(REG_SURFACE_WIDTH, 511));
        add_row(reg_row(REG_SURFACE_HEIGHT, 1));
        add_row(checked(fill_row(250, -5, 2047, 2047, rgba(128, 64, 32, 255)),
                        FILL_DONE));
        add_row(checked(read_row(255, 0), pixel_reply(rgba(128, 64, 32, 255))));
        // Reads past the surface still see the store.
        add_row(checked(read_row(250, 1), pixel_reply('0)));
        // One column, full height, faintest alpha: mixes over painted pixels and
        // overwrites clear ones.
        add_row(reg_row(REG_SURFACE_WIDTH, 1));
        add_row(reg_row(REG_SURFACE_HEIGHT, 256));
        add_row(fill_row(-1, -2048, 1, 2047, rgba(255, 255, 255, 1)));
        add_row(checked(read_row(0, 200), pixel_reply(rgba(255, 255, 255, 1))));
        add_row(read_row(0, 0));
        // Zero height.
        add_row(reg_row(REG_SURFACE_HEIGHT, 0));
        add_row(checked(fill_row(0, 0, 5, 5, rgba(7, 7, 7, 255)), FILL_DONE));
        // Back to a full surface with an oversized height; empty and reversed rectangles.
        add_row(reg_row(REG_SURFACE_WIDTH, 256));
        add_row(reg_row(REG_SURFACE_HEIGHT, 511));
        add_row(checked(fill_row(10, 10, 10, 20, rgba(5, 6, 7, 255)), FILL_DONE));
        add_row(checked(fill_row(2047, 2047, -2048, -2048, rgba(5, 6, 7, 255)),
                        FILL_DONE));
        // Single pixel: overwrite on a clear pixel, then a near-opaque blend over it.
        add_row(fill_row(100, 100, 101, 101, rgba(0, 0, 0, 254)));
        add_row(fill_row(100, 100, 101, 101, rgba(255, 255, 255, 254)));
        add_row(read_row(100, 100));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REGISTER)
                write_surface(plan[i].reg_sel, int'(plan[i].reg_val));
            else
                issue(plan[i].item, plan[i].typed, plan[i].reply);
        end

        // Random part in three idling phases, each under its own surface setting.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 78;
                write_surface(REG_SURFACE_WIDTH, 256);
                write_surface(REG_SURFACE_HEIGHT, 256);
            end
            else if (phase == 1)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 31;
                write_surface(REG_SURFACE_WIDTH, $urandom_range(40, 255));
                write_surface(REG_SURFACE_HEIGHT, $urandom_range(40, 255));
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_surface(REG_SURFACE_WIDTH, $urandom_range(257, 511));
                write_surface(REG_SURFACE_HEIGHT, 511);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // A fresh window now and then lands on clear pixels again, so the
                // overwrite path of a clear destination keeps being reached.
                if (n % SCENE_LEN == 0)
                begin
                    span_x = ((int'(shadow_w) > FRAME_W) ? FRAME_W : int'(shadow_w))
                             - WINDOW_SPAN;
                    span_y = ((int'(shadow_h) > FRAME_H) ? FRAME_H : int'(shadow_h))
                             - WINDOW_SPAN;
                    wx = $urandom_range(0, (span_x > 0) ? span_x : 0);
                    wy = $urandom_range(0, (span_y > 0) ? span_y : 0);
                end
                issue(random_request(wx, wy), 1'b0, FILL_DONE);
            end
        end

        req.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d fills and %0d reads, %0d register writes, %0d replies checked.",
                 fill_count, read_count, reg_writes, reply_count);
        $display("Predicted pixel updates: %0d blended, %0d overwritten; %0d faults found.",
                 mixed_pixels, overwritten_pixels, fault_count);
        if (fault_count == 0 && pending_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
